[hdl/fst_pkg.sv]
// Shared types and constants for the FSK symbol timing loop.
// Depends on nothing; used by the interfaces, the DC filter and the top level.
`timescale 1ns / 1ps
`default_nettype none
package fst_pkg;

  // Fraction bits of the DC estimate and the largest useful filter shift.
  localparam int FRAC_BITS    = 24;
  localparam int MAX_DC_SHIFT = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PHASE_SPAN    = 3'd0;
  localparam cfg_idx_t CFG_PHASE_STEP    = 3'd1;
  localparam cfg_idx_t CFG_DC_ENABLE     = 3'd2;
  localparam cfg_idx_t CFG_DC_SHIFT      = 3'd3;
  localparam cfg_idx_t CFG_LOCKED_GAIN   = 3'd4;
  localparam cfg_idx_t CFG_UNLOCKED_GAIN = 3'd5;
  localparam cfg_idx_t CFG_TIMEOUT_LIMIT = 3'd6;

  // Register reset values.
  localparam logic [31:0] RST_PHASE_SPAN    = 32'd4800000;
  localparam logic [31:0] RST_PHASE_STEP    = 32'd120000;
  localparam logic        RST_DC_ENABLE     = 1'b1;
  localparam logic [4:0]  RST_DC_SHIFT      = 5'd12;
  localparam logic [15:0] RST_LOCKED_GAIN   = 16'd6554;
  localparam logic [15:0] RST_UNLOCKED_GAIN = 16'd26214;
  localparam logic [7:0]  RST_TIMEOUT_LIMIT = 8'd32;

  // Sign of the DC-corrected sample, as the DC filter reports it.
  typedef struct packed {
    logic neg;
    logic pos;
  } corr_sign_t;

  // One result item.
  typedef struct packed {
    logic       symbol_valid;
    logic       bit_value;
    logic       locked;
    logic [7:0] mid_crossings;
  } result_t;

endpackage
`default_nettype wire

[hdl/fst_ifs.sv]
// Handshake channel interfaces of the FSK symbol timing loop: input samples,
// result items and configuration writes. Depends on fst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fst_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          invert;
  logic                          set_lock;

  modport source (output valid, sample, invert, set_lock, input ready);
  modport sink   (input valid, sample, invert, set_lock, output ready);
endinterface

interface fst_out_if ();
  logic       valid;
  logic       ready;
  logic       symbol_valid;
  logic       bit_value;
  logic       locked;
  logic [7:0] mid_crossings;

  modport source (output valid, symbol_valid, bit_value, locked, mid_crossings, input ready);
  modport sink   (input valid, symbol_valid, bit_value, locked, mid_crossings, output ready);
endinterface

interface fst_cfg_if ();
  logic              valid;
  logic              ready;
  fst_pkg::cfg_idx_t index;
  logic [31:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/fst_dc_filter.sv]
// DC removal for the symbol timing loop: a shift-based exponential average
// and the sign of the corrected sample. Depends on fst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fst_dc_filter #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step_en,
  input  wire logic                        enable,
  input  wire logic [4:0]                  shift,
  input  wire logic signed [SAMPLE_BITS:0] value,
  output      fst_pkg::corr_sign_t         corr_sign
);

  // The estimate stays between the scaled extremes of the sample.
  localparam int DW = SAMPLE_BITS + 1 + fst_pkg::FRAC_BITS + 1;

  logic signed [DW-1:0] dc_r;
  logic signed [DW-1:0] dc_nxt;
  logic signed [DW-1:0] scaled;
  logic signed [DW:0]   diff;
  logic signed [DW:0]   diff_sh;
  logic signed [DW:0]   corr;
  logic [4:0]           shift_c;

  // Clamp the time constant to its useful range.
  assign shift_c = (shift > 5'(fst_pkg::MAX_DC_SHIFT)) ? 5'(fst_pkg::MAX_DC_SHIFT) : shift;

  // Arithmetic shift right is the floor of the division by a power of two.
  always_comb begin
    scaled  = DW'(value) <<< fst_pkg::FRAC_BITS;
    diff    = (DW+1)'(scaled) - (DW+1)'(dc_r);
    diff_sh = diff >>> shift_c;
    dc_nxt  = enable ? (dc_r + DW'(diff_sh)) : dc_r;
    corr    = (DW+1)'(scaled) - (DW+1)'(dc_nxt);
    corr_sign.neg = corr[DW];
    corr_sign.pos = !corr[DW] && (corr != '0);
  end

  // The estimate advances once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= '0;
    end else if (step_en) begin
      dc_r <= dc_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/fsk_symbol_timing_pll.sv]
// Symbol timing recovery for a binary FSK demodulator. The block accepts one
// signed sample per clock cycle while the result side takes items, and
// presents one result item per sample: an input register, then a single pass
// of logic that runs the DC filter, the mid-symbol vote, the zero-crossing
// phase correction (one 32x16 multiply) and the accumulator wrap, into a result
// register. The loop state updates once per sample, so the sustained rate is
// one item per cycle whenever the result side takes items. Configuration is a
// separate write channel that is always ready; write it only while the block
// is idle. Depends on fst_pkg, fst_ifs and fst_dc_filter.
`timescale 1ns / 1ps
`default_nettype none
module fsk_symbol_timing_pll #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fst_in_if.sink     in_if,
  fst_out_if.source  out_if,
  fst_cfg_if.sink    cfg_if
);

  // Configuration registers.
  logic [31:0] phase_span_r;
  logic [31:0] phase_step_r;
  logic        dc_enable_r;
  logic [4:0]  dc_shift_r;
  logic [15:0] locked_gain_r;
  logic [15:0] unlocked_gain_r;
  logic [7:0]  timeout_limit_r;

  // Input register and result register.
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_invert_r;
  logic                          s1_set_lock_r;
  logic                          out_valid_r;
  fst_pkg::result_t              out_r;
  fst_pkg::result_t              res_nxt;

  // Loop state.
  logic [31:0] phase_r,    phase_nxt;
  logic        prev_neg_r;
  logic [15:0] votes_hi_r, votes_hi_nxt;
  logic [15:0] votes_lo_r, votes_lo_nxt;
  logic [7:0]  cross_r,    cross_nxt;
  logic [7:0]  idle_r,     idle_nxt;
  logic        lock_r,     lock_nxt;

  logic advance;
  logic step_en;
  logic in_acc;

  logic signed [SAMPLE_BITS:0] value;
  fst_pkg::corr_sign_t         corr_sign;

  logic        lock0;
  logic [35:0] phase_x10;
  logic [35:0] span_x9;
  logic        mid;
  logic        first_half;
  logic        err_neg;
  logic [31:0] err_mag;
  logic [15:0] gain;
  logic [47:0] corr_prod;
  logic [31:0] corr_mag;
  logic        crossing;
  logic [31:0] phase_c;
  logic [32:0] phase_s;
  logic [32:0] phase_w;
  logic        wrap;
  logic [7:0]  cross1;
  logic [7:0]  idle1;
  logic [7:0]  idle2;
  logic [15:0] votes_hi1;
  logic [15:0] votes_lo1;
  logic        vote_bit;

  // Handshake: the result register frees the single-pass stage.
  assign advance      = !out_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || advance;
  assign in_acc       = in_if.valid && in_if.ready;
  assign step_en      = s1_valid_r && advance;
  assign cfg_if.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_span_r    <= fst_pkg::RST_PHASE_SPAN;
      phase_step_r    <= fst_pkg::RST_PHASE_STEP;
      dc_enable_r     <= fst_pkg::RST_DC_ENABLE;
      dc_shift_r      <= fst_pkg::RST_DC_SHIFT;
      locked_gain_r   <= fst_pkg::RST_LOCKED_GAIN;
      unlocked_gain_r <= fst_pkg::RST_UNLOCKED_GAIN;
      timeout_limit_r <= fst_pkg::RST_TIMEOUT_LIMIT;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        fst_pkg::CFG_PHASE_SPAN:    phase_span_r    <= cfg_if.data;
        fst_pkg::CFG_PHASE_STEP:    phase_step_r    <= cfg_if.data;
        fst_pkg::CFG_DC_ENABLE:     dc_enable_r     <= cfg_if.data[0];
        fst_pkg::CFG_DC_SHIFT:      dc_shift_r      <= cfg_if.data[4:0];
        fst_pkg::CFG_LOCKED_GAIN:   locked_gain_r   <= cfg_if.data[15:0];
        fst_pkg::CFG_UNLOCKED_GAIN: unlocked_gain_r <= cfg_if.data[15:0];
        fst_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_if.data[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r   <= in_if.sample;
      s1_invert_r   <= in_if.invert;
      s1_set_lock_r <= in_if.set_lock;
    end
  end

  // Polarity: the negation of the most negative sample needs one more bit.
  assign value = s1_invert_r ? -(SAMPLE_BITS+1)'(s1_sample_r) : (SAMPLE_BITS+1)'(s1_sample_r);

  fst_dc_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dc_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .enable    (dc_enable_r),
    .shift     (dc_shift_r),
    .value     (value),
    .corr_sign (corr_sign)
  );

  // Phase windows, as integer compares against the span.
  always_comb begin
    phase_x10  = {1'b0, phase_r, 3'b000} + {3'b000, phase_r, 1'b0};
    span_x9    = {1'b0, phase_span_r, 3'b000} + {4'b0000, phase_span_r};
    mid        = (phase_x10 > {4'b0000, phase_span_r}) && (phase_x10 < span_x9);
    first_half = {phase_r, 1'b0} < {1'b0, phase_span_r};
  end

  // Phase error toward the nearest symbol edge, scaled by the loop gain.
  always_comb begin
    lock0   = lock_r || s1_set_lock_r;
    gain    = lock0 ? locked_gain_r : unlocked_gain_r;
    err_neg = 1'b0;
    if (first_half) begin
      err_mag = phase_r;
    end else if (phase_r >= phase_span_r) begin
      err_mag = phase_r - phase_span_r;
    end else begin
      err_mag = phase_span_r - phase_r;
      err_neg = 1'b1;
    end
    corr_prod = {16'd0, err_mag} * {32'd0, gain};
    corr_mag  = corr_prod[47:16];
  end

  // Crossing handling, accumulator advance and symbol boundary.
  always_comb begin
    crossing = corr_sign.neg != prev_neg_r;

    phase_c = phase_r;
    cross1  = cross_r;
    idle1   = idle_r;
    if (crossing) begin
      phase_c = err_neg ? (phase_r + corr_mag) : (phase_r - corr_mag);
      cross1  = mid ? ((cross_r == 8'hFF) ? cross_r : cross_r + 8'd1) : 8'd0;
      idle1   = 8'd0;
    end

    votes_hi1 = votes_hi_r;
    votes_lo1 = votes_lo_r;
    if (mid && corr_sign.pos && votes_hi_r != 16'hFFFF) begin
      votes_hi1 = votes_hi_r + 16'd1;
    end
    if (mid && !corr_sign.pos && votes_lo_r != 16'hFFFF) begin
      votes_lo1 = votes_lo_r + 16'd1;
    end

    phase_s = {1'b0, phase_c} + {1'b0, phase_step_r};
    wrap    = phase_s >= {1'b0, phase_span_r};
    phase_w = wrap ? (phase_s - {1'b0, phase_span_r}) : phase_s;
    phase_nxt = phase_w[32] ? 32'hFFFF_FFFF : phase_w[31:0];

    // Majority vote, or the current sign when nothing was voted.
    if (votes_hi1 != 16'd0 || votes_lo1 != 16'd0) begin
      vote_bit = votes_hi1 >= votes_lo1;
    end else begin
      vote_bit = corr_sign.pos;
    end

    idle2        = (idle1 == 8'hFF) ? idle1 : idle1 + 8'd1;
    cross_nxt    = cross1;
    votes_hi_nxt = votes_hi1;
    votes_lo_nxt = votes_lo1;
    idle_nxt     = idle1;
    lock_nxt     = lock0;
    if (wrap) begin
      cross_nxt    = 8'd0;
      votes_hi_nxt = 16'd0;
      votes_lo_nxt = 16'd0;
      idle_nxt     = idle2;
      if (idle2 > timeout_limit_r) begin
        lock_nxt = 1'b0;
      end
    end

    res_nxt.symbol_valid  = wrap;
    res_nxt.bit_value     = wrap && vote_bit;
    res_nxt.locked        = lock_nxt;
    res_nxt.mid_crossings = cross1;
  end

  // Loop state advances with each processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      prev_neg_r <= 1'b0;
      votes_hi_r <= '0;
      votes_lo_r <= '0;
      cross_r    <= '0;
      idle_r     <= '0;
      lock_r     <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      prev_neg_r <= corr_sign.neg;
      votes_hi_r <= votes_hi_nxt;
      votes_lo_r <= votes_lo_nxt;
      cross_r    <= cross_nxt;
      idle_r     <= idle_nxt;
      lock_r     <= lock_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.symbol_valid  = out_r.symbol_valid;
  assign out_if.bit_value     = out_r.bit_value;
  assign out_if.locked        = out_r.locked;
  assign out_if.mid_crossings = out_r.mid_crossings;

endmodule
`default_nettype wire
